// ===== src/srtr_pkg.sv =====
// Shared types, constants and the report length table of the stylus-to-touch report rewriter.
package srtr_pkg;

    // Widest coordinate that the emit command carries.
    localparam int MAX_COORD_BITS = 16;

    // Bytes in the appended touch report.
    localparam int TOUCH_LEN = 6;

    // Report ID of a stylus report.
    localparam logic [7:0] STYLUS_ID = 8'h01;

    // Tip and in-range bits of the touch report while the stylus is down.
    localparam logic [7:0] TIP_BITS = 8'h03;

    // Configuration register indexes.
    localparam logic [7:0] CFG_MIRROR_X = 8'd0;
    localparam logic [7:0] CFG_MIRROR_Y = 8'd1;
    localparam logic [7:0] CFG_JUMP_LIMIT = 8'd2;
    localparam logic [7:0] CFG_TOUCH_ID = 8'd3;

    // Position inside a stylus report.
    localparam logic [1:0] OFF_NONE = 2'd0;
    localparam logic [1:0] OFF_FLAGS = 2'd1;
    localparam logic [1:0] OFF_XLOW = 2'd2;
    localparam logic [1:0] OFF_YLOW = 2'd3;

    // Byte positions inside the touch report.
    localparam logic [2:0] POS_ID = 3'd0;
    localparam logic [2:0] POS_TIP = 3'd1;
    localparam logic [2:0] POS_XLO = 3'd2;
    localparam logic [2:0] POS_XHI = 3'd3;
    localparam logic [2:0] POS_YLO = 3'd4;
    localparam logic [2:0] POS_YHI = 3'd5;

    // Configuration as seen by the parser.
    typedef struct packed {
        logic        mirror_x;
        logic        mirror_y;
        logic [10:0] jump_limit;
    } t_cfg;

    // What the back end needs to close one transfer.
    typedef struct packed {
        logic                      append;
        logic                      tip;
        logic [MAX_COORD_BITS-1:0] x;
        logic [MAX_COORD_BITS-1:0] y;
    } t_emit_cmd;

    // Total length of a report by its ID; zero stops parsing.
    function automatic logic [6:0] report_len(input logic [7:0] id);
        logic [6:0] len;
        case (id)
            8'd1:    len = 7'd4;
            8'd2:    len = 7'd2;
            8'd3:    len = 7'd5;
            8'd4:    len = 7'd2;
            8'd5:    len = 7'd3;
            8'd6:    len = 7'd3;
            8'd7:    len = 7'd4;
            8'd8:    len = 7'd4;
            8'd9:    len = 7'd5;
            8'd20:   len = 7'd4;
            8'd21:   len = 7'd2;
            8'd32:   len = 7'd64;
            default: len = 7'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== src/stylus_report_to_touch_report.sv =====
// Top level of the stylus-to-touch report rewriter: configuration registers and the three stages.
//
//  Channel   Direction  Handshake                 Contents
//  s (in)    slave      i_s_tvalid / o_s_tready   tdata: data byte; tuser: byte valid;
//                                                 tlast: end of transfer
//  m (out)   master     o_m_tvalid / i_m_tready   tdata: report byte; tuser: appended;
//                                                 tlast: last result of the transfer
//  cfg       slave      i_cfg_valid / o_cfg_ready index 0..3, 11-bit data
//
// Each input byte is parsed in the cycle of its transfer, so the input takes one item per
// cycle while the queue is not full. An end of transfer pushes one command into a two-entry
// queue; the emitter picks a command up and then sends it as the six bytes of a touch report
// or as a plain end marker. The emitter holds one command besides the queue, so the input
// stalls while three closed transfers are waiting on the output side.
// Reset is synchronous and active low; it restores the register defaults and clears control state.
module stylus_report_to_touch_report #(
    parameter int BUFFER_BYTES = 64,
    parameter int COORD_BITS   = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] byte_valid
    input  logic        i_s_tlast,   // end_of_transfer
    // Output stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte
    output logic        o_m_tuser,   // [0] appended
    output logic        o_m_tlast,   // last_in_run
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    // Configuration registers; writes land at any time and are used as they stand.
    logic        r_mirror_x;
    logic        r_mirror_y;
    logic [10:0] r_jump_limit;
    logic [7:0]  r_touch_id;

    srtr_pkg::t_cfg      cfg;
    srtr_pkg::t_emit_cmd push_cmd, pop_cmd;
    logic                push, q_full, q_valid, pop, in_accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror_x   <= 1'b1;
            r_mirror_y   <= 1'b1;
            r_jump_limit <= 11'd256;
            r_touch_id   <= 8'h7f;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                srtr_pkg::CFG_MIRROR_X:   r_mirror_x   <= i_cfg_data[0];
                srtr_pkg::CFG_MIRROR_Y:   r_mirror_y   <= i_cfg_data[0];
                srtr_pkg::CFG_JUMP_LIMIT: r_jump_limit <= i_cfg_data;
                srtr_pkg::CFG_TOUCH_ID:   r_touch_id   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.mirror_x   = r_mirror_x;
    assign cfg.mirror_y   = r_mirror_y;
    assign cfg.jump_limit = r_jump_limit;

    // The parser never blocks on its own; only a full queue holds the input back.
    assign o_s_tready = !q_full;
    assign in_accept  = i_s_tvalid && o_s_tready;

    srtr_front #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .COORD_BITS   (COORD_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_data_byte       (i_s_tdata),
        .i_byte_valid      (i_s_tuser),
        .i_end_of_transfer (i_s_tlast),
        .i_cfg             (cfg),
        .o_push            (push),
        .o_cmd             (push_cmd)
    );

    srtr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (pop_cmd)
    );

    srtr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_cmd    (pop_cmd),
        .o_q_pop    (pop),
        .i_touch_id (r_touch_id),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_byte     (o_m_tdata),
        .o_appended (o_m_tuser),
        .o_last     (o_m_tlast)
    );

endmodule

// ===== src/srtr_front.sv =====
// Parser: walks the byte stream as reports, tracks the stylus position, and issues emit commands.
module srtr_front #(
    parameter int BUFFER_BYTES = 64,
    parameter int COORD_BITS   = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_byte_valid,
    input  logic               i_end_of_transfer,
    input  srtr_pkg::t_cfg     i_cfg,
    output logic               o_push,
    output srtr_pkg::t_emit_cmd o_cmd
);

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam int CMP_W = (COORD_BITS > 11) ? COORD_BITS : 11;

    logic [6:0]            r_left, n_left;
    logic                  r_stopped, n_stopped;
    logic [1:0]            r_off, n_off;
    logic [7:0]            r_flags, n_flags;
    logic [7:0]            r_xlow, n_xlow;
    logic [COORD_BITS-1:0] r_last_x, n_last_x;
    logic [COORD_BITS-1:0] r_last_y, n_last_y;
    logic                  r_recent, n_recent;
    logic                  r_touch, n_touch;
    logic [CNT_W-1:0]      r_cnt, n_cnt;

    logic [6:0]            len;
    logic [COORD_BITS-1:0] pt_x, pt_y, dx, dy;
    logic                  near;
    logic                  emit;

    // Candidate point from the stored flags and X low byte plus the incoming Y low byte.
    always_comb begin
        pt_x = COORD_BITS'({r_flags[3:2], r_xlow});
        pt_y = COORD_BITS'({r_flags[1:0], i_data_byte});
        if (i_cfg.mirror_x) begin
            pt_x = ~pt_x;
        end
        if (i_cfg.mirror_y) begin
            pt_y = ~pt_y;
        end
        dx = (r_last_x > pt_x) ? (r_last_x - pt_x) : (pt_x - r_last_x);
        dy = (r_last_y > pt_y) ? (r_last_y - pt_y) : (pt_y - r_last_y);
        near = (CMP_W'(dx) < CMP_W'(i_cfg.jump_limit))
            && (CMP_W'(dy) < CMP_W'(i_cfg.jump_limit));
    end

    always_comb begin
        n_left    = r_left;
        n_stopped = r_stopped;
        n_off     = r_off;
        n_flags   = r_flags;
        n_xlow    = r_xlow;
        n_last_x  = r_last_x;
        n_last_y  = r_last_y;
        n_recent  = r_recent;
        n_touch   = r_touch;
        n_cnt     = r_cnt;
        len       = srtr_pkg::report_len(i_data_byte);
        emit      = 1'b0;
        o_push    = 1'b0;
        o_cmd     = '0;

        if (i_accept && i_byte_valid) begin
            if (r_cnt < CNT_W'(BUFFER_BYTES)) begin
                n_cnt = r_cnt + 1'b1;
            end
            if (!r_stopped) begin
                if (r_left == 7'd0) begin
                    if (len == 7'd0) begin
                        n_stopped = 1'b1;
                        n_off     = srtr_pkg::OFF_NONE;
                    end else begin
                        n_left = len - 7'd1;
                        n_off  = (i_data_byte == srtr_pkg::STYLUS_ID) ?
                                 srtr_pkg::OFF_FLAGS : srtr_pkg::OFF_NONE;
                    end
                end else begin
                    n_left = r_left - 7'd1;
                    case (r_off)
                        srtr_pkg::OFF_FLAGS: begin
                            n_flags = i_data_byte;
                            n_off   = srtr_pkg::OFF_XLOW;
                        end
                        srtr_pkg::OFF_XLOW: begin
                            n_xlow = i_data_byte;
                            n_off  = srtr_pkg::OFF_YLOW;
                        end
                        srtr_pkg::OFF_YLOW: begin
                            if (!r_recent || near) begin
                                n_last_x = pt_x;
                                n_last_y = pt_y;
                            end
                            n_recent = 1'b1;
                            n_touch  = 1'b1;
                            n_off    = srtr_pkg::OFF_NONE;
                        end
                        default: begin
                            n_off = srtr_pkg::OFF_NONE;
                        end
                    endcase
                end
            end
        end

        if (i_accept && i_end_of_transfer) begin
            emit = n_recent
                && (n_cnt <= CNT_W'(BUFFER_BYTES - srtr_pkg::TOUCH_LEN));
            o_push       = 1'b1;
            o_cmd.append = emit;
            o_cmd.tip    = n_touch;
            o_cmd.x      = srtr_pkg::MAX_COORD_BITS'(n_last_x);
            o_cmd.y      = srtr_pkg::MAX_COORD_BITS'(n_last_y);
            if (emit) begin
                n_recent = n_touch;
            end
            n_left    = 7'd0;
            n_stopped = 1'b0;
            n_off     = srtr_pkg::OFF_NONE;
            n_touch   = 1'b0;
            n_cnt     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= 7'd0;
            r_stopped <= 1'b0;
            r_off     <= srtr_pkg::OFF_NONE;
            r_flags   <= 8'd0;
            r_xlow    <= 8'd0;
            r_last_x  <= '0;
            r_last_y  <= '0;
            r_recent  <= 1'b0;
            r_touch   <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_left    <= n_left;
            r_stopped <= n_stopped;
            r_off     <= n_off;
            r_flags   <= n_flags;
            r_xlow    <= n_xlow;
            r_last_x  <= n_last_x;
            r_last_y  <= n_last_y;
            r_recent  <= n_recent;
            r_touch   <= n_touch;
            r_cnt     <= n_cnt;
        end
    end

endmodule

// ===== src/srtr_queue.sv =====
// Two-entry queue of emit commands between the parser and the emitter.
module srtr_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  srtr_pkg::t_emit_cmd i_cmd,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output srtr_pkg::t_emit_cmd o_cmd
);

    srtr_pkg::t_emit_cmd r_entry [2];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/srtr_back.sv =====
// Emitter: turns each emit command into the touch report bytes or a lone end marker.
module srtr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  srtr_pkg::t_emit_cmd i_q_cmd,
    output logic                o_q_pop,
    input  logic [7:0]          i_touch_id,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_byte,
    output logic                o_appended,
    output logic                o_last
);

    srtr_pkg::t_emit_cmd r_cmd;
    logic                r_cmd_valid;
    logic [2:0]          r_pos;
    logic                r_out_valid;
    logic [7:0]          r_out_byte;
    logic                r_out_app;
    logic                r_out_last;

    logic       load;
    logic [7:0] sel_byte;
    logic       sel_last;

    assign o_q_pop = !r_cmd_valid;
    assign load    = r_cmd_valid && (!r_out_valid || i_ready);

    always_comb begin
        case (r_pos)
            srtr_pkg::POS_ID:  sel_byte = i_touch_id;
            srtr_pkg::POS_TIP: sel_byte = r_cmd.tip ? srtr_pkg::TIP_BITS : 8'h00;
            srtr_pkg::POS_XLO: sel_byte = r_cmd.x[7:0];
            srtr_pkg::POS_XHI: sel_byte = r_cmd.x[15:8];
            srtr_pkg::POS_YLO: sel_byte = r_cmd.y[7:0];
            default:           sel_byte = r_cmd.y[15:8];
        endcase
        if (!r_cmd.append) begin
            sel_byte = 8'h00;
        end
        sel_last = !r_cmd.append || (r_pos == srtr_pkg::POS_YHI);
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= sel_byte;
            r_out_app  <= r_cmd.append;
            r_out_last <= sel_last;
        end
        if (!r_cmd_valid) begin
            r_cmd <= i_q_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
            r_pos       <= srtr_pkg::POS_ID;
            r_out_valid <= 1'b0;
        end else begin
            if (!r_cmd_valid) begin
                r_cmd_valid <= i_q_valid;
                r_pos       <= srtr_pkg::POS_ID;
            end else if (load) begin
                r_pos <= r_pos + 3'd1;
                if (sel_last) begin
                    r_cmd_valid <= 1'b0;
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_byte     = r_out_byte;
    assign o_appended = r_out_app;
    assign o_last     = r_out_last;

endmodule

// ===== src/srtr_check.sv =====
// Port-level checker for the stylus-to-touch report rewriter, bound to the top level.
module srtr_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata,
    input logic        o_m_tuser,
    input logic        o_m_tlast
);

    // A stalled output transfer keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output changed while stalled");

    // A transfer without an appended report is a single end marker.
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tlast && (o_m_tdata == 8'h00))
        else $error("end marker malformed");

    // Touch report bytes follow one another without gaps.
    a_report_dense: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tuser && !o_m_tlast |=> o_m_tvalid && o_m_tuser)
        else $error("gap inside touch report");

    // Nothing is offered right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind stylus_report_to_touch_report srtr_check u_srtr_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
